[hdl/ccu_pkg.sv]
// ----------------------------------------------------------------------------
// ccu_pkg
// Shared codes, control word layout and the microcode table of the
// comparison closure update block.
// ----------------------------------------------------------------------------
package ccu_pkg;

  // Field widths fixed by the stream format (variables index a space of 16)
  localparam int VAR_W  = 4;
  localparam int CNT_W  = 5;   // holds a variable count up to 16
  localparam int REL_W  = 2;
  localparam int FUNC_W = 2;
  localparam int STAT_W = 3;

  localparam int DEF_MAX_VARS = 12;
  localparam logic [VAR_W-1:0] ACTIVE_RESET = 4'd12;

  // Item functions
  localparam logic [FUNC_W-1:0] FN_CLEAR  = 2'd0;
  localparam logic [FUNC_W-1:0] FN_RECORD = 2'd1;
  localparam logic [FUNC_W-1:0] FN_QUERY  = 2'd2;
  localparam logic [FUNC_W-1:0] FN_NONE   = 2'd3;

  // Pair relation codes, row owner versus column
  localparam logic [REL_W-1:0] REL_UNTESTED = 2'd0;
  localparam logic [REL_W-1:0] REL_GREATER  = 2'd1;
  localparam logic [REL_W-1:0] REL_LESS     = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_RECORDED = 3'd0;
  localparam logic [STAT_W-1:0] ST_KNOWN    = 3'd1;
  localparam logic [STAT_W-1:0] ST_CONTRA   = 3'd2;
  localparam logic [STAT_W-1:0] ST_INVALID  = 3'd3;
  localparam logic [STAT_W-1:0] ST_CLEARED  = 3'd4;

  // Program steps; the step after the last one wraps to fetch
  typedef enum logic [2:0] {
    STEP_FETCH,
    STEP_DISPATCH,
    STEP_READ_B,
    STEP_LOAD_B,
    STEP_DECIDE,
    STEP_PRIME,
    STEP_SWEEP,
    STEP_RESP
  } step_t;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_A,
    RD_B,
    RD_CNT
  } rd_sel_t;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_IDLE,
    COND_SHORT,
    COND_NO_CLOSE,
    COND_MORE,
    COND_STALL
  } cond_t;

  typedef struct packed {
    logic    take;      // input handshake open
    rd_sel_t rd_sel;    // row memory read address source
    logic    latch_a;   // capture row of first variable
    logic    latch_b;   // capture row of second variable
    logic    classify;  // load status for clear and invalid items
    logic    decide;    // load status, down and up sets
    logic    cnt_clr;
    logic    sweep;     // write the closed row back
    logic    respond;   // load the result register
    cond_t   cond;
    step_t   target;    // jump target when cond holds
  } ctrl_t;

  typedef struct packed {
    logic short_item;   // clear, unused function or invalid pair
    logic no_close;     // query or record that changes nothing
    logic more;         // rows left to read in the sweep
    logic out_busy;     // result register full and not taken
  } flags_t;

  // Microcode ROM
  function automatic ctrl_t ucode(step_t s);
    ctrl_t w;
    w = '0;
    w.cond   = COND_NEVER;
    w.target = STEP_FETCH;
    w.rd_sel = RD_NONE;
    unique case (s)
      STEP_FETCH: begin
        w.take   = 1'b1;
        w.cond   = COND_IDLE;
        w.target = STEP_FETCH;
      end
      STEP_DISPATCH: begin
        w.rd_sel   = RD_A;
        w.classify = 1'b1;
        w.cond     = COND_SHORT;
        w.target   = STEP_RESP;
      end
      STEP_READ_B: begin
        w.rd_sel  = RD_B;
        w.latch_a = 1'b1;
      end
      STEP_LOAD_B: begin
        w.latch_b = 1'b1;
      end
      STEP_DECIDE: begin
        w.decide  = 1'b1;
        w.cnt_clr = 1'b1;
        w.cond    = COND_NO_CLOSE;
        w.target  = STEP_RESP;
      end
      STEP_PRIME: begin
        w.rd_sel = RD_CNT;
      end
      STEP_SWEEP: begin
        w.rd_sel = RD_CNT;
        w.sweep  = 1'b1;
        w.cond   = COND_MORE;
        w.target = STEP_SWEEP;
      end
      STEP_RESP: begin
        w.respond = 1'b1;
        w.cond    = COND_STALL;
        w.target  = STEP_RESP;
      end
      default: begin
        w = '0;
      end
    endcase
    return w;
  endfunction

endpackage

[hdl/ccu_seq.sv]
// ----------------------------------------------------------------------------
// ccu_seq
// Step counter of the microcoded sequencer: fetches the control word and
// resolves conditional jumps.
// ----------------------------------------------------------------------------
module ccu_seq (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  input  ccu_pkg::flags_t flags,
  output ccu_pkg::ctrl_t  ctrl,
  output logic           s_tready
);

  ccu_pkg::step_t pc;
  ccu_pkg::step_t pc_next;
  logic           cond_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= ccu_pkg::STEP_FETCH;
    end else begin
      pc <= pc_next;
    end
  end

  always_comb begin
    ctrl     = ccu_pkg::ucode(pc);
    s_tready = ctrl.take;
  end

  always_comb begin
    unique case (ctrl.cond)
      ccu_pkg::COND_NEVER:    cond_hit = 1'b0;
      ccu_pkg::COND_IDLE:     cond_hit = !s_tvalid;
      ccu_pkg::COND_SHORT:    cond_hit = flags.short_item;
      ccu_pkg::COND_NO_CLOSE: cond_hit = flags.no_close;
      ccu_pkg::COND_MORE:     cond_hit = flags.more;
      ccu_pkg::COND_STALL:    cond_hit = flags.out_busy;
      default:                cond_hit = 1'b0;
    endcase
    // fall through to the next step, wrapping from respond to fetch
    pc_next = cond_hit ? ctrl.target : ccu_pkg::step_t'(3'(pc + 3'd1));
  end

endmodule

[hdl/ccu_dp.sv]
// ----------------------------------------------------------------------------
// ccu_dp
// Datapath: relation row memory, item registers, closure row update and
// the result register.
// ----------------------------------------------------------------------------
module ccu_dp #(
  parameter int MAX_VARS = ccu_pkg::DEF_MAX_VARS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  ccu_pkg::ctrl_t              ctrl,
  input  logic                        s_tvalid,
  input  logic [ccu_pkg::FUNC_W-1:0]  func,
  input  logic [ccu_pkg::VAR_W-1:0]   first_var,
  input  logic [ccu_pkg::VAR_W-1:0]   second_var,
  input  logic [ccu_pkg::REL_W-1:0]   relation,
  input  logic                        cfg_we,
  input  logic [ccu_pkg::VAR_W-1:0]   cfg_wdata,
  input  logic                        m_tready,
  output logic                        m_tvalid,
  output logic [ccu_pkg::STAT_W-1:0]  status,
  output logic [ccu_pkg::REL_W-1:0]   relation_before,
  output ccu_pkg::flags_t             flags
);

  localparam int ROW_W = $clog2(MAX_VARS);

  // Row x holds x versus every column variable
  typedef logic [MAX_VARS-1:0][ccu_pkg::REL_W-1:0] row_t;

  row_t                        mem [MAX_VARS];
  logic [MAX_VARS-1:0]         row_valid;

  logic [ccu_pkg::VAR_W-1:0]   active_count;
  logic [ccu_pkg::CNT_W-1:0]   n_eff;

  logic [ccu_pkg::FUNC_W-1:0]  func_q;
  logic [ccu_pkg::VAR_W-1:0]   a_q;
  logic [ccu_pkg::VAR_W-1:0]   b_q;
  logic [ccu_pkg::REL_W-1:0]   rel_q;

  logic [ROW_W-1:0]            a_ix;
  logic [ROW_W-1:0]            b_ix;
  logic [ROW_W-1:0]            l_ix;
  logic [ROW_W-1:0]            g_ix;

  logic                        rd_en;
  logic [ROW_W-1:0]            rd_addr;
  logic [ROW_W-1:0]            rd_row;
  row_t                        rdata;
  logic                        rvalid;
  row_t                        row_old;
  row_t                        row_new;
  row_t                        row_a;
  row_t                        row_b;
  row_t                        row_l;
  row_t                        row_g;

  logic [ccu_pkg::CNT_W-1:0]   cnt;
  logic [MAX_VARS-1:0]         down;
  logic [MAX_VARS-1:0]         up;
  logic [MAX_VARS-1:0]         down_next;
  logic [MAX_VARS-1:0]         up_next;

  logic                        bad_pair;
  logic                        bad_rel;
  logic [ccu_pkg::REL_W-1:0]   prior_rel;
  logic [ccu_pkg::STAT_W-1:0]  res_status;
  logic [ccu_pkg::REL_W-1:0]   res_before;
  logic                        load_out;

  // Configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      active_count <= ccu_pkg::ACTIVE_RESET;
    end else if (cfg_we) begin
      active_count <= cfg_wdata;
    end
  end

  assign n_eff = (ccu_pkg::CNT_W'(active_count) < ccu_pkg::CNT_W'(MAX_VARS)) ?
                 ccu_pkg::CNT_W'(active_count) : ccu_pkg::CNT_W'(MAX_VARS);

  // Input beat
  always_ff @(posedge clk) begin
    if (ctrl.take && s_tvalid) begin
      func_q <= func;
      a_q    <= first_var;
      b_q    <= second_var;
      rel_q  <= relation;
    end
  end

  assign a_ix = a_q[ROW_W-1:0];
  assign b_ix = b_q[ROW_W-1:0];
  assign l_ix = (rel_q == ccu_pkg::REL_LESS) ? a_ix : b_ix;
  assign g_ix = (rel_q == ccu_pkg::REL_LESS) ? b_ix : a_ix;

  assign bad_pair = (a_q == b_q) ||
                    (ccu_pkg::CNT_W'(a_q) >= n_eff) ||
                    (ccu_pkg::CNT_W'(b_q) >= n_eff);
  assign flags.short_item = (func_q == ccu_pkg::FN_CLEAR) ||
                            (func_q == ccu_pkg::FN_NONE) || bad_pair;

  // Row memory read port
  assign flags.more = ccu_pkg::CNT_W'(cnt) < n_eff;

  always_comb begin
    case (ctrl.rd_sel)
      ccu_pkg::RD_A: begin
        rd_en   = !flags.short_item;
        rd_addr = a_ix;
      end
      ccu_pkg::RD_B: begin
        rd_en   = 1'b1;
        rd_addr = b_ix;
      end
      ccu_pkg::RD_CNT: begin
        rd_en   = flags.more;
        rd_addr = cnt[ROW_W-1:0];
      end
      default: begin
        rd_en   = 1'b0;
        rd_addr = a_ix;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata  <= mem[rd_addr];
      rvalid <= row_valid[rd_addr];
      rd_row <= rd_addr;
    end
  end

  // A row never written reads as all untested
  assign row_old = rvalid ? rdata : '0;

  always_ff @(posedge clk) begin
    if (ctrl.latch_a) begin
      row_a <= row_old;
    end
    if (ctrl.latch_b) begin
      row_b <= row_old;
    end
  end

  // Decide: outcome of the item and the closure sets
  assign prior_rel = row_a[b_ix];
  assign bad_rel = (rel_q != ccu_pkg::REL_GREATER) && (rel_q != ccu_pkg::REL_LESS);
  assign flags.no_close = (func_q == ccu_pkg::FN_QUERY) || bad_rel ||
                          (prior_rel != ccu_pkg::REL_UNTESTED);

  assign row_l = (rel_q == ccu_pkg::REL_LESS) ? row_a : row_b;
  assign row_g = (rel_q == ccu_pkg::REL_LESS) ? row_b : row_a;

  always_comb begin
    for (int x = 0; x < MAX_VARS; x++) begin
      down_next[x] = (ccu_pkg::CNT_W'(x) < n_eff) &&
                     ((ROW_W'(x) == l_ix) || (row_l[x] == ccu_pkg::REL_GREATER));
      up_next[x]   = (ccu_pkg::CNT_W'(x) < n_eff) &&
                     ((ROW_W'(x) == g_ix) || (row_g[x] == ccu_pkg::REL_LESS));
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.classify) begin
      res_status <= (func_q == ccu_pkg::FN_CLEAR) ? ccu_pkg::ST_CLEARED : ccu_pkg::ST_INVALID;
      res_before <= ccu_pkg::REL_UNTESTED;
    end else if (ctrl.decide) begin
      down <= down_next;
      up   <= up_next;
      if (func_q == ccu_pkg::FN_QUERY) begin
        res_status <= ccu_pkg::ST_KNOWN;
        res_before <= prior_rel;
      end else if (bad_rel) begin
        res_status <= ccu_pkg::ST_INVALID;
        res_before <= ccu_pkg::REL_UNTESTED;
      end else begin
        res_before <= prior_rel;
        if (prior_rel == rel_q) begin
          res_status <= ccu_pkg::ST_KNOWN;
        end else if (prior_rel != ccu_pkg::REL_UNTESTED) begin
          res_status <= ccu_pkg::ST_CONTRA;
        end else begin
          res_status <= ccu_pkg::ST_RECORDED;
        end
      end
    end
  end

  // Sweep counter: next row to read
  always_ff @(posedge clk) begin
    if (ctrl.cnt_clr) begin
      cnt <= '0;
    end else if (ctrl.rd_sel == ccu_pkg::RD_CNT && flags.more) begin
      cnt <= cnt + 1'b1;
    end
  end

  // Closed row: a pair whose members sit in both sets takes the lower
  // index as the greater one, the order in which overlapping writes land
  always_comb begin
    logic wd;
    logic wu;
    row_new = row_old;
    for (int y = 0; y < MAX_VARS; y++) begin
      wd = down[rd_row] && up[y];
      wu = up[rd_row] && down[y];
      if (ROW_W'(y) != rd_row) begin
        if (wd && wu) begin
          row_new[y] = (rd_row < ROW_W'(y)) ? ccu_pkg::REL_GREATER : ccu_pkg::REL_LESS;
        end else if (wd) begin
          row_new[y] = ccu_pkg::REL_LESS;
        end else if (wu) begin
          row_new[y] = ccu_pkg::REL_GREATER;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.sweep) begin
      mem[rd_row] <= row_new;
    end
  end

  // Result register
  assign flags.out_busy = m_tvalid && !m_tready;
  assign load_out = ctrl.respond && !flags.out_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid  <= 1'b0;
      row_valid <= '0;
    end else begin
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (load_out && func_q == ccu_pkg::FN_CLEAR) begin
        row_valid <= '0;
      end else if (ctrl.sweep) begin
        row_valid[rd_row] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      status          <= res_status;
      relation_before <= res_before;
    end
  end

  a_sweep_no_collide: assert property (@(posedge clk) disable iff (rst)
    ctrl.sweep && rd_en |-> rd_addr != rd_row)
    else $error("sweep reads the row it writes");

  a_sweep_active_row: assert property (@(posedge clk) disable iff (rst)
    ctrl.sweep |-> ccu_pkg::CNT_W'(rd_row) < n_eff)
    else $error("sweep writes an inactive row");

  a_recorded_was_open: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && status == ccu_pkg::ST_RECORDED |-> relation_before == ccu_pkg::REL_UNTESTED)
    else $error("recorded pair was not untested");

  a_contra_was_known: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && status == ccu_pkg::ST_CONTRA |-> relation_before != ccu_pkg::REL_UNTESTED)
    else $error("contradiction on an untested pair");

endmodule

[hdl/comparison_closure_update.sv]
// ----------------------------------------------------------------------------
// comparison_closure_update
// Incremental transitive closure store for pairwise comparisons.
// ----------------------------------------------------------------------------
// One item is worked at a time and each gives one result beat. A clear, an
// invalid pair or an unused function goes from dispatch straight to the
// result; a query and a record that changes nothing skip the closure sweep;
// a record that closes runs the closure sweep over n rows, n being
// min(active_count, MAX_VARS); the sweep reads and writes one relation row
// per cycle through the row memory. The next input beat is taken while the
// last result still waits; the block stalls only when a second result is
// ready and the first has not been taken. Reset and clear need no sweep:
// every row has a valid bit, and a row without it reads as untested.
// ----------------------------------------------------------------------------
module comparison_closure_update #(
  parameter int MAX_VARS = ccu_pkg::DEF_MAX_VARS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [3:0] first_var, [7:4] second_var, [9:8] relation
  input  logic [1:0]  s_tuser,   // [1:0] func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [1:0] relation_before
  output logic [2:0]  m_tuser,   // [2:0] status
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata  // active_count
);

  ccu_pkg::ctrl_t  ctrl;
  ccu_pkg::flags_t flags;
  logic [ccu_pkg::REL_W-1:0] relation_before;

  ccu_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .flags    (flags),
    .ctrl     (ctrl),
    .s_tready (s_tready)
  );

  ccu_dp #(
    .MAX_VARS (MAX_VARS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .ctrl            (ctrl),
    .s_tvalid        (s_tvalid),
    .func            (s_tuser),
    .first_var       (s_tdata[3:0]),
    .second_var      (s_tdata[7:4]),
    .relation        (s_tdata[9:8]),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .m_tready        (m_tready),
    .m_tvalid        (m_tvalid),
    .status          (m_tuser),
    .relation_before (relation_before),
    .flags           (flags)
  );

  assign m_tdata = {6'b0, relation_before};

endmodule

[bench/ccu_checker.sv]
// ----------------------------------------------------------------------------
// ccu_checker
// Watches the item, result and configuration channels of the comparison
// closure update block. Keeps its own pair relation table and count, works
// out the answer to every accepted item and compares each result beat with
// the oldest answer still due.
// ----------------------------------------------------------------------------
import ccu_pkg::*;

module ccu_checker #(
  parameter int MAX_VARS = DEF_MAX_VARS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,   // [3:0] first_var, [7:4] second_var, [9:8] relation
  input  logic [1:0]  s_tuser,   // [1:0] func
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,   // [1:0] relation_before
  input  logic [2:0]  m_tuser,   // [2:0] status
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata, // active_count
  output int          pending,
  output int          fail_count
);

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [REL_W-1:0]  rel_before;
  } answer_t;

  // Only entries [lo][hi] with lo < hi are used, held as "lo versus hi"
  logic [REL_W-1:0] order_tab [16][16];
  logic [VAR_W-1:0] active_cfg;
  answer_t          answers_due [$];

  function automatic logic [REL_W-1:0] flip(input logic [REL_W-1:0] r);
    if (r == REL_GREATER) return REL_LESS;
    if (r == REL_LESS) return REL_GREATER;
    return REL_UNTESTED;
  endfunction

  function automatic logic [REL_W-1:0] pair_rel(input int x, input int y);
    if (x == y || x >= MAX_VARS || y >= MAX_VARS) return REL_UNTESTED;
    return (x < y) ? order_tab[x][y] : flip(order_tab[y][x]);
  endfunction

  // Mark x as less than y
  function automatic void set_less(input int x, input int y);
    if (x < y) order_tab[x][y] = REL_LESS;
    else order_tab[y][x] = REL_GREATER;
  endfunction

  function automatic answer_t record_or_read(input logic [FUNC_W-1:0] fn,
                                             input int a, input int b,
                                             input logic [REL_W-1:0] rl);
    answer_t          ans;
    int               n;
    int               lesser;
    int               greater;
    logic [REL_W-1:0] prior;
    logic             down [16];
    logic             up [16];
    ans.status     = ST_INVALID;
    ans.rel_before = REL_UNTESTED;
    n = (int'(active_cfg) < MAX_VARS) ? int'(active_cfg) : MAX_VARS;
    if (fn == FN_CLEAR) begin
      foreach (order_tab[i, j]) order_tab[i][j] = REL_UNTESTED;
      ans.status = ST_CLEARED;
      return ans;
    end
    if (fn == FN_NONE || a == b || a >= n || b >= n) return ans;
    prior = pair_rel(a, b);
    if (fn == FN_QUERY) begin
      ans.status     = ST_KNOWN;
      ans.rel_before = prior;
      return ans;
    end
    if (rl != REL_GREATER && rl != REL_LESS) return ans;
    ans.rel_before = prior;
    if (prior == rl) begin
      ans.status = ST_KNOWN;
      return ans;
    end
    if (prior != REL_UNTESTED) begin
      ans.status = ST_CONTRA;
      return ans;
    end
    lesser  = (rl == REL_LESS) ? a : b;
    greater = (rl == REL_LESS) ? b : a;
    // Both sets come from the table as it stood before this item
    for (int x = 0; x < n; x++) begin
      down[x] = (x == lesser) || (pair_rel(x, lesser) == REL_LESS);
      up[x]   = (x == greater) || (pair_rel(x, greater) == REL_GREATER);
    end
    for (int x = 0; x < n; x++)
      for (int y = 0; y < n; y++)
        if (down[x] && up[y] && x != y) set_less(x, y);
    ans.status = ST_RECORDED;
    return ans;
  endfunction

  initial fail_count = 0;

  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      foreach (order_tab[i, j]) order_tab[i][j] = REL_UNTESTED;
      active_cfg = ACTIVE_RESET;
      answers_due.delete();
    end else begin
      if (cfg_we) active_cfg = cfg_wdata;
      if (s_tvalid && s_tready)
        answers_due.push_back(record_or_read(s_tuser, int'(s_tdata[3:0]),
                                             int'(s_tdata[7:4]), s_tdata[9:8]));
      if (m_tvalid && m_tready) begin
        if (answers_due.size() == 0) begin
          $error("result beat with no item outstanding: status %0d, relation_before %0d",
                 m_tuser, m_tdata[1:0]);
          fail_count++;
        end else begin
          want = answers_due.pop_front();
          if (m_tuser !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, m_tuser);
            fail_count++;
          end
          if (m_tdata[1:0] !== want.rel_before) begin
            $error("relation_before mismatch: expected %0d, got %0d",
                   want.rel_before, m_tdata[1:0]);
            fail_count++;
          end
        end
      end
    end
    pending <= answers_due.size();
  end

endmodule

[bench/tb_comparison_closure_update.sv]
// ----------------------------------------------------------------------------
// tb_comparison_closure_update
// Drives the comparison closure update block with a directed opening and
// then phases of random records, queries, clears and malformed items under
// varying variable counts, with random gaps and stalls on both sides and one
// long result hold-off. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_comparison_closure_update;
  import ccu_pkg::*;

  localparam int MAX_VARS        = DEF_MAX_VARS;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int DRAIN_CYCLES    = 24;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;
  logic [2:0]  m_tuser;
  logic        cfg_we;
  logic [3:0]  cfg_wdata;

  int pending;
  int fail_count;
  int sent = 0;
  int rx_beats = 0;
  int idle_cycles = 0;

  comparison_closure_update #(.MAX_VARS(MAX_VARS)) dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  ccu_checker #(.MAX_VARS(MAX_VARS)) chk (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .pending    (pending),
    .fail_count (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Offer one item beat; keep valid high when no gap is drawn
  task automatic send_item(input logic [FUNC_W-1:0] fn, input int a, input int b,
                           input logic [REL_W-1:0] rl);
    int gap;
    if ((sent / 100) % 4 == 2) gap = 0;
    else gap = $urandom_range(0, 12);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= fn;
    s_tdata  <= {6'd0, rl, b[3:0], a[3:0]};
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  // Drop valid and wait until every result has been taken
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_random(input int n);
    int pick;
    int a;
    int b;
    pick = $urandom_range(0, 99);
    a = $urandom_range(0, n - 1);
    b = $urandom_range(0, n - 2);
    if (b >= a) b++;
    if (pick < 55)
      send_item(FN_RECORD, a, b, $urandom_range(0, 1) ? REL_GREATER : REL_LESS);
    else if (pick < 82)
      send_item(FN_QUERY, a, b, REL_W'($urandom_range(0, 3)));
    else if (pick < 84)
      send_item(FN_CLEAR, $urandom_range(0, 15), $urandom_range(0, 15),
                REL_W'($urandom_range(0, 3)));
    else
      send_item(FUNC_W'($urandom_range(0, 3)), $urandom_range(0, 15),
                $urandom_range(0, 15), REL_W'($urandom_range(0, 3)));
  endtask

  // Result side: random stalls, one long hold-off to back up the block
  initial begin
    int stall;
    m_tready = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (rx_beats == 300) stall = 400;
      else if ((rx_beats / 90) % 4 == 3) stall = 0;
      else stall = $urandom_range(0, 12);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      rx_beats++;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int count;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = FN_CLEAR;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed opening at the reset count
    send_item(FN_QUERY, 0, 11, REL_UNTESTED);
    send_item(FN_RECORD, 0, 1, REL_LESS);
    send_item(FN_RECORD, 1, 2, REL_LESS);
    send_item(FN_RECORD, 5, 4, REL_GREATER);
    send_item(FN_RECORD, 2, 4, REL_LESS);      // joins the two chains
    send_item(FN_QUERY, 5, 0, REL_UNTESTED);
    send_item(FN_RECORD, 0, 1, REL_LESS);      // same relation again
    send_item(FN_RECORD, 4, 1, REL_LESS);      // opposite of the closure
    send_item(FN_RECORD, 11, 10, REL_GREATER);
    send_item(FN_RECORD, 3, 3, REL_LESS);      // equal variables
    send_item(FN_RECORD, 12, 0, REL_LESS);     // past the active count
    send_item(FN_QUERY, 0, 15, REL_UNTESTED);
    send_item(FN_RECORD, 0, 3, REL_UNTESTED);  // bad relation codes
    send_item(FN_RECORD, 0, 3, 2'd3);
    send_item(FN_NONE, 15, 15, 2'd3);
    send_item(FN_QUERY, 1, 0, REL_UNTESTED);
    send_item(FN_CLEAR, 15, 15, 2'd3);
    send_item(FN_QUERY, 0, 1, REL_UNTESTED);
    send_item(FN_RECORD, 10, 0, REL_GREATER);
    send_item(FN_QUERY, 0, 10, REL_UNTESTED);

    for (int p = 0; p < PHASES; p++) begin
      if (p == 0) count = 2;
      else if (p == 1 || p == PHASES - 1) count = MAX_VARS;
      else count = $urandom_range(2, MAX_VARS);
      settle();
      cfg_we    <= 1'b1;
      cfg_wdata <= count[3:0];
      @(posedge clk);
      cfg_we    <= 1'b0;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) send_random(count);
    end

    settle();
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

[files.f]
hdl/ccu_pkg.sv
hdl/ccu_seq.sv
hdl/ccu_dp.sv
hdl/comparison_closure_update.sv
bench/ccu_checker.sv
bench/tb_comparison_closure_update.sv
